FILE: src/gsm_pkg.sv
`default_nettype none

package gsm_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam int TOL_W   = 31;
    localparam int STEPS_W = 8;
    localparam int INDEX_W = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // 1/phi and 1/phi^2 as unsigned Q0.32
    localparam logic [31:0] INV_PHI_Q32  = 32'd2654435769;
    localparam logic [31:0] INV_PHI2_Q32 = 32'd1640531527;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd66;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd64;
    localparam logic [STEPS_W-1:0] STEPS_SAT   = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_X_TOLERANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 8'd1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_VALUE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PROBE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINAL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd2;

    typedef struct packed {
        logic [TOL_W-1:0]   x_tolerance;
        logic [STEPS_W-1:0] max_steps;
    } t_cfg;

endpackage

`default_nettype wire

FILE: src/gsm_if.sv
`default_nettype none

interface gsm_in_if #(
    parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [DATA_WIDTH-1:0]  bound_one;
    logic signed [DATA_WIDTH-1:0]  bound_two;
    logic [gsm_pkg::INDEX_W-1:0]   equation_index;
    logic signed [DATA_WIDTH-1:0]  probe_value;

    modport source (
        output valid, command, bound_one, bound_two, equation_index, probe_value,
        input  ready
    );
    modport sink (
        input  valid, command, bound_one, bound_two, equation_index, probe_value,
        output ready
    );
endinterface

interface gsm_out_if #(
    parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [gsm_pkg::KIND_W-1:0]    kind;
    logic signed [DATA_WIDTH-1:0]  point;
    logic [gsm_pkg::INDEX_W-1:0]   probe_index;
    logic [gsm_pkg::STEPS_W-1:0]   steps_taken;

    modport source (
        output valid, kind, point, probe_index, steps_taken,
        input  ready
    );
    modport sink (
        input  valid, kind, point, probe_index, steps_taken,
        output ready
    );
endinterface

interface gsm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gsm_pkg::CFG_IDX_W-1:0]   index;
    logic [gsm_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/gsm_cfg_regs.sv
`default_nettype none

module gsm_cfg_regs (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    gsm_cfg_if.sink        i_cfg,
    output gsm_pkg::t_cfg  o_cfg
);

    logic [gsm_pkg::TOL_W-1:0]   r_tol;
    logic [gsm_pkg::STEPS_W-1:0] r_max;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= gsm_pkg::TOL_RESET;
            r_max <= gsm_pkg::STEPS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gsm_pkg::CFG_X_TOLERANCE: begin
                    r_tol <= i_cfg.data[gsm_pkg::TOL_W-1:0];
                end
                gsm_pkg::CFG_MAX_STEPS: begin
                    r_max <= i_cfg.data[gsm_pkg::STEPS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.x_tolerance = r_tol;
    assign o_cfg.max_steps   = r_max;

endmodule

`default_nettype wire

FILE: src/gsm_core.sv
`default_nettype none

module gsm_core #(
    parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_fire,
    input  wire gsm_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_command,
    input  wire logic [DATA_WIDTH-1:0]              i_bound_one,
    input  wire logic [DATA_WIDTH-1:0]              i_bound_two,
    input  wire logic [gsm_pkg::INDEX_W-1:0]        i_equation_index,
    input  wire logic [DATA_WIDTH-1:0]              i_probe_value,
    output logic [gsm_pkg::KIND_W-1:0]              o_kind,
    output logic [DATA_WIDTH-1:0]                   o_point,
    output logic [gsm_pkg::INDEX_W-1:0]             o_probe_index,
    output logic [gsm_pkg::STEPS_W-1:0]             o_steps_taken
);

    localparam int CMP_W  = (DATA_WIDTH > gsm_pkg::TOL_W) ? DATA_WIDTH : gsm_pkg::TOL_W;
    localparam int PROD_W = DATA_WIDTH + 32;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_PROBE  = 2'd3;

    // round(w * k / 2^32), ties up
    function automatic logic [DATA_WIDTH-1:0] scale_q32(
        input logic [DATA_WIDTH-1:0] w,
        input logic [31:0]           k
    );
        logic [PROD_W-1:0] p;
        p = {{32{1'b0}}, w} * {{DATA_WIDTH{1'b0}}, k};
        p = p + (PROD_W'(1) << 31);
        return p[PROD_W-1:32];
    endfunction

    logic [DATA_WIDTH-1:0]        r_lower, r_upper, r_il, r_ir, r_lv, r_rv, r_width;
    logic [DATA_WIDTH-1:0]        n_lower, n_upper, n_il, n_ir, n_lv, n_rv, n_width;
    logic [1:0]                   r_phase, n_phase;
    logic                         r_npl, n_npl;
    logic [gsm_pkg::STEPS_W-1:0]  r_steps, n_steps;
    logic [gsm_pkg::INDEX_W-1:0]  r_held, n_held;

    logic [DATA_WIDTH-1:0] cur_lv, cur_rv;
    logic [DATA_WIDTH-1:0] s_lower, s_upper, calc_lower, calc_width;
    logic [DATA_WIDTH-1:0] off_left, off_right;
    logic [DATA_WIDTH-1:0] il_calc, ir_calc;
    logic                  keep_left, swap, narrow, stop;

    assign swap       = $signed(i_bound_two) < $signed(i_bound_one);
    assign s_lower    = swap ? i_bound_two : i_bound_one;
    assign s_upper    = swap ? i_bound_one : i_bound_two;
    assign cur_lv     = (r_phase == PH_PROBE && r_npl) ? i_probe_value : r_lv;
    assign cur_rv     = (r_phase == PH_PROBE && r_npl) ? r_rv : i_probe_value;
    assign keep_left  = $signed(cur_lv) < $signed(cur_rv);
    assign calc_lower = (i_command == gsm_pkg::CMD_START) ? s_lower
                      : (keep_left ? r_lower : r_il);
    assign calc_width = (i_command == gsm_pkg::CMD_START) ? s_upper - s_lower
                      : (keep_left ? r_ir - r_lower : r_upper - r_il);
    assign off_left   = scale_q32(calc_width, gsm_pkg::INV_PHI2_Q32);
    assign off_right  = scale_q32(calc_width, gsm_pkg::INV_PHI_Q32);
    assign il_calc    = calc_lower + off_left;
    assign ir_calc    = calc_lower + off_right;
    assign narrow     = CMP_W'(calc_width) <= CMP_W'(i_cfg.x_tolerance);

    always_comb begin
        n_lower = r_lower;
        n_upper = r_upper;
        n_il    = r_il;
        n_ir    = r_ir;
        n_lv    = r_lv;
        n_rv    = r_rv;
        n_width = r_width;
        n_phase = r_phase;
        n_npl   = r_npl;
        n_steps = r_steps;
        n_held  = r_held;
        stop    = 1'b0;

        o_kind        = gsm_pkg::KIND_IGNORED;
        o_point       = '0;
        o_probe_index = '0;
        o_steps_taken = r_steps;

        if (i_command == gsm_pkg::CMD_START) begin
            n_lower = s_lower;
            n_upper = s_upper;
            n_width = calc_width;
            n_il    = il_calc;
            n_ir    = ir_calc;
            n_held  = i_equation_index;
            n_steps = '0;
            o_probe_index = i_equation_index;
            o_steps_taken = '0;
            if (narrow) begin
                n_phase = PH_IDLE;
                o_kind  = gsm_pkg::KIND_FINAL;
                o_point = i_bound_one;
            end else begin
                n_phase = PH_FIRST;
                o_kind  = gsm_pkg::KIND_PROBE;
                o_point = il_calc;
            end
        end else begin
            case (r_phase)
                PH_FIRST: begin
                    n_lv    = i_probe_value;
                    n_phase = PH_SECOND;
                    o_kind  = gsm_pkg::KIND_PROBE;
                    o_point = r_ir;
                    o_probe_index = r_held;
                end
                PH_SECOND, PH_PROBE: begin
                    if (keep_left) begin
                        n_upper = r_ir;
                        n_ir    = r_il;
                        n_lv    = cur_lv;
                        n_rv    = cur_lv;
                        n_width = calc_width;
                        n_il    = il_calc;
                        n_npl   = 1'b1;
                        o_point = il_calc;
                    end else begin
                        n_lower = r_il;
                        n_il    = r_ir;
                        n_lv    = cur_rv;
                        n_rv    = cur_rv;
                        n_width = calc_width;
                        n_ir    = ir_calc;
                        n_npl   = 1'b0;
                        o_point = ir_calc;
                    end
                    if (r_steps != gsm_pkg::STEPS_SAT) begin
                        n_steps = r_steps + 1'b1;
                    end
                    stop = narrow || (n_steps >= i_cfg.max_steps);
                    o_probe_index = r_held;
                    o_steps_taken = n_steps;
                    if (stop) begin
                        n_phase = PH_IDLE;
                        o_kind  = gsm_pkg::KIND_FINAL;
                        o_point = n_lower + (n_width >> 1);
                    end else begin
                        n_phase = PH_PROBE;
                        o_kind  = gsm_pkg::KIND_PROBE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '0;
            r_il    <= '0;
            r_ir    <= '0;
            r_lv    <= '0;
            r_rv    <= '0;
            r_width <= '0;
            r_phase <= PH_IDLE;
            r_npl   <= 1'b0;
            r_steps <= '0;
            r_held  <= '0;
        end else if (i_fire) begin
            r_lower <= n_lower;
            r_upper <= n_upper;
            r_il    <= n_il;
            r_ir    <= n_ir;
            r_lv    <= n_lv;
            r_rv    <= n_rv;
            r_width <= n_width;
            r_phase <= n_phase;
            r_npl   <= n_npl;
            r_steps <= n_steps;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

FILE: src/golden_section_minimizer.sv
`default_nettype none

// an accepted input is held in the input register, then its result in the result register; a stalled output holds both
// one item per cycle while the output is ready; each step is a compare, two constant multiplies and adds
// sustained pace follows the partner that answers probe requests
// reset (synchronous, active low) clears the search state and both valid flags,
// and loads x_tolerance = 66 and max_steps = 64
module golden_section_minimizer #(
    parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gsm_in_if.sink     i_in,
    gsm_out_if.source  o_out,
    gsm_cfg_if.sink    i_cfg
);

    gsm_pkg::t_cfg cfg;

    logic                          r_in_valid;
    logic                          r_cmd;
    logic [DATA_WIDTH-1:0]         r_b1, r_b2, r_pv;
    logic [gsm_pkg::INDEX_W-1:0]   r_idx;

    logic                          r_out_valid;
    logic [gsm_pkg::KIND_W-1:0]    r_kind;
    logic [DATA_WIDTH-1:0]         r_point;
    logic [gsm_pkg::INDEX_W-1:0]   r_pidx;
    logic [gsm_pkg::STEPS_W-1:0]   r_steps;

    logic [gsm_pkg::KIND_W-1:0]    n_kind;
    logic [DATA_WIDTH-1:0]         n_point;
    logic [gsm_pkg::INDEX_W-1:0]   n_pidx;
    logic [gsm_pkg::STEPS_W-1:0]   n_steps;

    logic adv, fire, take;

    assign adv        = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && adv;
    assign i_in.ready = !r_in_valid || adv;
    assign take       = i_in.valid && i_in.ready;

    gsm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    gsm_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_cfg            (cfg),
        .i_command        (r_cmd),
        .i_bound_one      (r_b1),
        .i_bound_two      (r_b2),
        .i_equation_index (r_idx),
        .i_probe_value    (r_pv),
        .o_kind           (n_kind),
        .o_point          (n_point),
        .o_probe_index    (n_pidx),
        .o_steps_taken    (n_steps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_in.command;
            r_b1  <= i_in.bound_one;
            r_b2  <= i_in.bound_two;
            r_idx <= i_in.equation_index;
            r_pv  <= i_in.probe_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind  <= n_kind;
            r_point <= n_point;
            r_pidx  <= n_pidx;
            r_steps <= n_steps;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_kind;
    assign o_out.point       = r_point;
    assign o_out.probe_index = r_pidx;
    assign o_out.steps_taken = r_steps;

endmodule

`default_nettype wire
